FILE: rtl/core/lkg_pkg.sv
// Shared types and constants of the keyframe guard mode controller.
`timescale 1ns / 1ps

package lkg_pkg;

	// Field widths
	localparam int TYPE_W  = 2;
	localparam int CNT_W   = 32;
	localparam int BYTES_W = 48;
	localparam int TIME_W  = 32;
	localparam int THR_W   = 10;
	localparam int WIN_W   = 16;
	localparam int LOSS_W  = 10;
	localparam int RATE_W  = 32;

	// Derived widths of the loss arithmetic
	localparam int TOT_W = CNT_W + 1;
	localparam int LHS_W = CNT_W + LOSS_W;
	localparam int RHS_W = TOT_W + THR_W;

	// Shared divider: numerator, divisor and quotient widths
	localparam int DIV_N_W = BYTES_W + 3;
	localparam int DIV_D_W = TOT_W;
	localparam int DIV_Q_W = 32;
	localparam int DIV_C_W = $clog2(DIV_Q_W);

	localparam logic [LOSS_W-1:0] LOSS_SCALE = LOSS_W'(1000);
	localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(100);
	localparam logic [WIN_W-1:0]  WIN_RESET  = WIN_W'(2000);

	// Configuration port
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_LOSS_THR    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_UPSHIFT_WIN = CFG_IDX_W'(1);

	typedef enum logic [TYPE_W-1:0] {
		REQ_SAMPLE = 2'd0,
		REQ_FRAME  = 2'd1,
		REQ_GUARD  = 2'd2
	} req_t;

	// Controller to datapath
	typedef struct packed {
		logic latch;
		logic prep1;
		logic prep2;
		logic div_start;
		logic div_rate;
		logic loss_cap;
		logic commit;
	} lkg_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic in_is_sample;
		logic div_done;
	} lkg_stat_t;

endpackage

FILE: rtl/core/lkg_if.sv
// Channel interfaces: input items, result items and configuration writes.
`timescale 1ns / 1ps

interface lkg_item_if
	import lkg_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [TYPE_W-1:0]  req_type;
	logic [CNT_W-1:0]   rx_pkts;
	logic [CNT_W-1:0]   lost_pkts;
	logic [BYTES_W-1:0] rx_bytes;
	logic [TIME_W-1:0]  now_ms;
	logic               frame_corrupted;
	logic               frame_decode_only;
	logic               frame_is_delta;

	modport source (
		output valid, req_type, rx_pkts, lost_pkts, rx_bytes, now_ms,
		output frame_corrupted, frame_decode_only, frame_is_delta,
		input  ready
	);
	modport sink (
		input  valid, req_type, rx_pkts, lost_pkts, rx_bytes, now_ms,
		input  frame_corrupted, frame_decode_only, frame_is_delta,
		output ready
	);
endinterface

interface lkg_result_if
	import lkg_pkg::*;
;
	logic              valid;
	logic              ready;
	logic              pass_frame;
	logic              keyframe_only;
	logic              recovery_armed;
	logic              main_blocked;
	logic              show_guard;
	logic [LOSS_W-1:0] loss_permille;
	logic [RATE_W-1:0] rate_kbps;

	modport source (
		output valid, pass_frame, keyframe_only, recovery_armed, main_blocked, show_guard,
		output loss_permille, rate_kbps,
		input  ready
	);
	modport sink (
		input  valid, pass_frame, keyframe_only, recovery_armed, main_blocked, show_guard,
		input  loss_permille, rate_kbps,
		output ready
	);
endinterface

interface lkg_cfg_if
	import lkg_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/lkg_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module lkg_div
	import lkg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIV_N_W-1:0] num,
	input  logic [DIV_D_W-1:0] den,
	output logic [DIV_Q_W-1:0] quo,
	output logic               done
);

	localparam int HI_W = DIV_N_W - DIV_Q_W;

	logic [DIV_D_W-1:0] rem_q;
	logic [DIV_D_W-1:0] den_q;
	logic [DIV_Q_W-1:0] quo_q;
	logic [DIV_C_W-1:0] cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [DIV_D_W:0] trial;
	logic [DIV_D_W:0] diff;
	logic             ge;

	// Caller guarantees num[high part] < den, so the quotient fits DIV_Q_W bits.
	assign trial = {rem_q, quo_q[DIV_Q_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_C_W'(DIV_Q_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {{(DIV_D_W - HI_W){1'b0}}, num[DIV_N_W-1:DIV_Q_W]};
			quo_q <= num[DIV_Q_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
			quo_q <= {quo_q[DIV_Q_W-2:0], ge};
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

FILE: rtl/core/lkg_dp.sv
// Datapath: item registers, interval deltas, loss compare, mode flags, result register.
`timescale 1ns / 1ps

module lkg_dp
	import lkg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  lkg_cmd_t              cmd,
	output lkg_stat_t             stat,
	input  logic [TYPE_W-1:0]     req_type,
	input  logic [CNT_W-1:0]      rx_pkts,
	input  logic [CNT_W-1:0]      lost_pkts,
	input  logic [BYTES_W-1:0]    rx_bytes,
	input  logic [TIME_W-1:0]     now_ms,
	input  logic                  frame_corrupted,
	input  logic                  frame_decode_only,
	input  logic                  frame_is_delta,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  pass_frame,
	output logic                  keyframe_only,
	output logic                  recovery_armed,
	output logic                  main_blocked,
	output logic                  show_guard,
	output logic [LOSS_W-1:0]     loss_permille,
	output logic [RATE_W-1:0]     rate_kbps
);

	// Configuration
	logic [THR_W-1:0] thr_q;
	logic [WIN_W-1:0] win_q;

	// Mode state
	logic              mode_q, rec_q, gr_q, gs_q, mb_q;
	logic [TIME_W-1:0] lls_q;
	logic [TOT_W-1:0]  prev_tot_q;
	logic [CNT_W-1:0]  prev_lost_q;
	logic [BYTES_W-1:0] prev_bytes_q;
	logic [TIME_W-1:0] prev_time_q;

	// Latched item
	logic [TYPE_W-1:0]  typ_q;
	logic [TOT_W-1:0]   cur_tot_q;
	logic [CNT_W-1:0]   lost_q;
	logic [BYTES_W-1:0] bytes_q;
	logic [TIME_W-1:0]  now_q;
	logic               corr_q, deco_q, delta_q;

	// Working registers
	logic [TOT_W-1:0]   dt_q;
	logic [CNT_W-1:0]   dl_q;
	logic [BYTES_W-1:0] db_q;
	logic [TIME_W-1:0]  dms_q;
	logic               rate_ok_q;
	logic               el_ge_q;
	logic [LHS_W-1:0]   lhs_q;
	logic [RHS_W-1:0]   rhs_q;
	logic               sat_q;
	logic               dt_zero_q;
	logic               dl_gt_q;
	logic [LOSS_W-1:0]  loss_div_q;

	// Result register
	logic              pass_q, out_mode_q, out_rec_q, out_mb_q, out_gs_q;
	logic [LOSS_W-1:0] loss_q;
	logic [RATE_W-1:0] rate_q;

	// Divider
	logic [DIV_N_W-1:0] div_num;
	logic [DIV_D_W-1:0] div_den;
	logic [DIV_Q_W-1:0] div_quo;
	logic               div_done;

	// Next state
	logic              mode_n, rec_n, gr_n, gs_n, mb_n;
	logic [TIME_W-1:0] lls_n;
	logic              pass_n;
	logic [LOSS_W-1:0] loss_n;
	logic [RATE_W-1:0] rate_n;
	logic              gt, eq;
	logic [TIME_W-1:0] elapsed;

	assign stat.in_is_sample = (req_type == REQ_SAMPLE);
	assign stat.div_done     = div_done;

	assign div_num = cmd.div_rate ? {db_q, 3'b000} : DIV_N_W'(lhs_q);
	assign div_den = cmd.div_rate ? DIV_D_W'(dms_q) : dt_q;

	lkg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.done   (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
			win_q <= WIN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOSS_THR:    thr_q <= cfg_data[THR_W-1:0];
				REG_UPSHIFT_WIN: win_q <= cfg_data[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Payload and working registers
	assign elapsed = now_q - lls_q;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			typ_q     <= req_type;
			cur_tot_q <= TOT_W'(rx_pkts) + TOT_W'(lost_pkts);
			lost_q    <= lost_pkts;
			bytes_q   <= rx_bytes;
			now_q     <= now_ms;
			corr_q    <= frame_corrupted;
			deco_q    <= frame_decode_only;
			delta_q   <= frame_is_delta;
		end
		if (cmd.prep1) begin
			dt_q      <= (cur_tot_q >= prev_tot_q) ? cur_tot_q - prev_tot_q : '0;
			dl_q      <= (lost_q >= prev_lost_q) ? lost_q - prev_lost_q : '0;
			db_q      <= bytes_q - prev_bytes_q;
			dms_q     <= now_q - prev_time_q;
			rate_ok_q <= (prev_time_q != '0) && (now_q > prev_time_q) &&
				(bytes_q >= prev_bytes_q);
			// time going backward counts as zero elapsed
			el_ge_q   <= (now_q >= lls_q) ? (elapsed >= TIME_W'(win_q)) : (win_q == '0);
		end
		if (cmd.prep2) begin
			lhs_q     <= LHS_W'(dl_q) * LHS_W'(LOSS_SCALE);
			rhs_q     <= RHS_W'(thr_q) * RHS_W'(dt_q);
			// bytes*8 / ms overflows 32 bits when (bytes*8) >> 32 >= ms
			sat_q     <= TIME_W'(db_q[BYTES_W-1:BYTES_W-(DIV_N_W-DIV_Q_W)]) >= dms_q;
			dt_zero_q <= (dt_q == '0);
			dl_gt_q   <= TOT_W'(dl_q) > dt_q;
		end
		if (cmd.loss_cap) begin
			loss_div_q <= div_quo[LOSS_W-1:0];
		end
		if (cmd.commit) begin
			pass_q     <= pass_n;
			out_mode_q <= mode_n;
			out_rec_q  <= rec_n;
			out_mb_q   <= mb_n;
			out_gs_q   <= gs_n;
			loss_q     <= loss_n;
			rate_q     <= rate_n;
		end
	end

	assign gt = !dt_zero_q && (RHS_W'(lhs_q) > rhs_q);
	assign eq = dt_zero_q ? (thr_q == '0) : (RHS_W'(lhs_q) == rhs_q);

	always_comb begin
		mode_n = mode_q;
		rec_n  = rec_q;
		gr_n   = gr_q;
		gs_n   = gs_q;
		mb_n   = mb_q;
		lls_n  = lls_q;
		pass_n = 1'b0;
		loss_n = '0;
		rate_n = '0;
		case (typ_q)
			REQ_SAMPLE: begin
				if (gt) begin
					lls_n = '0;
					rec_n = 1'b0;
					if (!mode_q) begin
						mode_n = 1'b1;
						mb_n   = 1'b1;
						if (gr_q) begin
							gs_n = 1'b1;
						end
					end
				end else if (!mode_q || eq) begin
					lls_n = '0;
				end else if (!rec_q) begin
					if (lls_q == '0) begin
						lls_n = now_q;
					end else if (el_ge_q) begin
						lls_n = '0;
						rec_n = 1'b1;
					end
				end
				if (dt_zero_q) begin
					loss_n = '0;
				end else if (dl_gt_q) begin
					loss_n = LOSS_SCALE;
				end else begin
					loss_n = loss_div_q;
				end
				if (!rate_ok_q) begin
					rate_n = '0;
				end else if (sat_q) begin
					rate_n = '1;
				end else begin
					rate_n = div_quo;
				end
			end
			REQ_FRAME: begin
				if (!corr_q && !deco_q && !(mode_q && delta_q)) begin
					pass_n = 1'b1;
					// clean keyframe with recovery armed restores main video
					if (rec_q && !delta_q) begin
						rec_n  = 1'b0;
						mode_n = 1'b0;
						mb_n   = 1'b0;
						gs_n   = 1'b0;
					end
				end
			end
			REQ_GUARD: begin
				gr_n = 1'b1;
				if (mode_q) begin
					gs_n = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= 1'b0;
			rec_q        <= 1'b0;
			gr_q         <= 1'b0;
			gs_q         <= 1'b0;
			mb_q         <= 1'b0;
			lls_q        <= '0;
			prev_tot_q   <= '0;
			prev_lost_q  <= '0;
			prev_bytes_q <= '0;
			prev_time_q  <= '0;
		end else if (cmd.commit) begin
			mode_q <= mode_n;
			rec_q  <= rec_n;
			gr_q   <= gr_n;
			gs_q   <= gs_n;
			mb_q   <= mb_n;
			lls_q  <= lls_n;
			if (typ_q == REQ_SAMPLE) begin
				prev_tot_q   <= cur_tot_q;
				prev_lost_q  <= lost_q;
				prev_bytes_q <= bytes_q;
				prev_time_q  <= now_q;
			end
		end
	end

	assign pass_frame     = pass_q;
	assign keyframe_only  = out_mode_q;
	assign recovery_armed = out_rec_q;
	assign main_blocked   = out_mb_q;
	assign show_guard     = out_gs_q;
	assign loss_permille  = loss_q;
	assign rate_kbps      = rate_q;

endmodule

FILE: rtl/core/lkg_ctrl.sv
// Controller: item sequencing, divider scheduling and result handshake.
`timescale 1ns / 1ps

module lkg_ctrl
	import lkg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  lkg_stat_t stat,
	output lkg_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP1,
		S_PREP2,
		S_LDIV,
		S_LWAIT,
		S_RDIV,
		S_RWAIT,
		S_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   commit;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	// result register is free once the previous beat leaves
	assign commit   = (state_q == S_FIN) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= stat.in_is_sample ? S_PREP1 : S_FIN;
					end
				end
				S_PREP1: state_q <= S_PREP2;
				S_PREP2: state_q <= S_LDIV;
				S_LDIV:  state_q <= S_LWAIT;
				S_LWAIT: begin
					if (stat.div_done) begin
						state_q <= S_RDIV;
					end
				end
				S_RDIV:  state_q <= S_RWAIT;
				S_RWAIT: begin
					if (stat.div_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.latch     = accept;
		cmd.prep1     = (state_q == S_PREP1);
		cmd.prep2     = (state_q == S_PREP2);
		cmd.div_start = (state_q == S_LDIV) || (state_q == S_RDIV);
		cmd.div_rate  = (state_q == S_RDIV);
		cmd.loss_cap  = (state_q == S_LWAIT) && stat.div_done;
		cmd.commit    = commit;
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/core/loss_driven_keyframe_guard_mode.sv
// Top level of the loss-driven keyframe guard mode controller.
// Usage:
//   item   : valid/ready input channel. req_type selects a statistics sample,
//            a decoded frame or a guard-ready notice; only the fields of that
//            kind are looked at.
//   result : valid/ready output channel, exactly one beat per item, carrying the
//            frame decision, the mode flags, loss in permille and rate in kbps.
//   cfg    : valid/ready write channel, always ready; index 0 is the loss
//            threshold, index 1 the upshift window. Other indexes are ignored.
// Sequence: from accept to result valid, a sample passes the PREP1 and PREP2
//   states, then two passes through one shared radix-2 divider
//   (start, 32 quotient bits, done; loss ratio first, then rate), then the
//   commit state. Frames and guard notices go straight to commit. One item is in
//   flight at a time; ready returns the cycle after commit, so a new item is
//   taken only once the previous one has committed.
// Reset clears the mode flags, interval history and result valid, and loads
//   the register defaults (threshold 100, window 2000 ms).
// A stalled result holds in the output register; the next item is still
//   accepted and waits for commit until the held beat is taken.
`timescale 1ns / 1ps

module loss_driven_keyframe_guard_mode
	import lkg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	lkg_item_if.sink    item,
	lkg_result_if.source result,
	lkg_cfg_if.sink     cfg
);

	lkg_cmd_t  cmd;
	lkg_stat_t stat;

	assign cfg.ready = 1'b1;

	lkg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lkg_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.req_type          (item.req_type),
		.rx_pkts           (item.rx_pkts),
		.lost_pkts         (item.lost_pkts),
		.rx_bytes          (item.rx_bytes),
		.now_ms            (item.now_ms),
		.frame_corrupted   (item.frame_corrupted),
		.frame_decode_only (item.frame_decode_only),
		.frame_is_delta    (item.frame_is_delta),
		.cfg_we            (cfg.valid && cfg.ready),
		.cfg_index         (cfg.index),
		.cfg_data          (cfg.data),
		.pass_frame        (result.pass_frame),
		.keyframe_only     (result.keyframe_only),
		.recovery_armed    (result.recovery_armed),
		.main_blocked      (result.main_blocked),
		.show_guard        (result.show_guard),
		.loss_permille     (result.loss_permille),
		.rate_kbps         (result.rate_kbps)
	);

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the loss-driven keyframe guard mode controller.
`timescale 1ns / 1ps

module tb_top
	import lkg_pkg::*;
;

	localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
	localparam int CLK_HI = 6;
	localparam int CLK_LO = 6;

	typedef struct packed {
		logic [TYPE_W-1:0]  kind;
		logic [CNT_W-1:0]   rx;
		logic [CNT_W-1:0]   lost;
		logic [BYTES_W-1:0] bytes;
		logic [TIME_W-1:0]  now;
		logic               corrupted;
		logic               dec_only;
		logic               delta;
	} rx_item_t;

	typedef struct packed {
		logic              pass_frame;
		logic              keyframe_only;
		logic              recovery_armed;
		logic              main_blocked;
		logic              show_guard;
		logic [LOSS_W-1:0] loss_permille;
		logic [RATE_W-1:0] rate_kbps;
	} verdict_t;

	logic clk;
	logic arst_n;

	lkg_item_if   item_ch ();
	lkg_result_if result_ch ();
	lkg_cfg_if    cfg_ch ();

	loss_driven_keyframe_guard_mode DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	always begin
		clk = 1'b1;
		#CLK_HI;
		clk = 1'b0;
		#CLK_LO;
	end

	// Mirror of the controller state and its registers
	logic [THR_W-1:0]   thr_pm;
	logic [WIN_W-1:0]   win_ms;
	logic               kf_only, recov_armed, guard_ready, guard_on, main_off;
	logic [TIME_W-1:0]  low_since;
	logic [CNT_W-1:0]   last_rx, last_lost;
	logic [BYTES_W-1:0] last_bytes;
	logic [TIME_W-1:0]  last_time;

	rx_item_t pending_items[$];
	verdict_t expected_verdicts[$];

	int unsigned fail_count = 0;
	int unsigned results_seen = 0;
	int unsigned n_samples = 0, n_frames = 0, n_passed = 0;
	int unsigned mode_entries = 0, restores = 0;
	logic        item_fire;

	// Stream state for well-formed statistics sequences
	logic [CNT_W-1:0]   s_rx = '0, s_lost = '0;
	logic [BYTES_W-1:0] s_bytes = '0;
	logic [TIME_W-1:0]  s_now = 32'd10000;
	int unsigned        bad_left = 0;

	function automatic verdict_t predict_verdict(input rx_item_t it);
		verdict_t v;
		logic [TOT_W-1:0]  tot_now, tot_was, d_tot;
		logic [CNT_W-1:0]  d_lost;
		logic [TIME_W-1:0] elapsed;
		logic [63:0]       lhs, rhs, q, d_bits, d_ms;
		int                cmp;
		v = '0;
		case (it.kind)
		REQ_SAMPLE: begin
			n_samples++;
			tot_now = TOT_W'(it.rx) + TOT_W'(it.lost);
			tot_was = TOT_W'(last_rx) + TOT_W'(last_lost);
			d_tot = (tot_now >= tot_was) ? tot_now - tot_was : '0;
			d_lost = (it.lost >= last_lost) ? it.lost - last_lost : '0;
			if (d_tot != '0) begin
				lhs = 64'(d_lost) * 64'd1000;
				rhs = 64'(thr_pm) * 64'(d_tot);
				cmp = (lhs > rhs) ? 1 : ((lhs == rhs) ? 0 : -1);
				q = lhs / 64'(d_tot);
				v.loss_permille = (q > 64'd1000) ? LOSS_W'(1000) : LOSS_W'(q);
			end else begin
				cmp = (thr_pm == '0) ? 0 : -1;
			end
			if (cmp > 0) begin
				low_since = '0;
				recov_armed = 1'b0;
				if (!kf_only) begin
					kf_only = 1'b1;
					main_off = 1'b1;
					if (guard_ready)
						guard_on = 1'b1;
					mode_entries++;
				end
			end else if (!kf_only || cmp == 0) begin
				low_since = '0;
			end else if (!recov_armed) begin
				// a start time of zero reads as "not started"
				if (low_since == '0) begin
					low_since = it.now;
				end else begin
					elapsed = (it.now >= low_since) ? it.now - low_since : '0;
					if (elapsed >= TIME_W'(win_ms)) begin
						low_since = '0;
						recov_armed = 1'b1;
					end
				end
			end
			if (last_time != '0 && it.now > last_time && it.bytes >= last_bytes) begin
				d_bits = 64'(it.bytes - last_bytes) * 64'd8;
				d_ms = 64'(it.now - last_time);
				q = d_bits / d_ms;
				v.rate_kbps = (q > 64'hFFFF_FFFF) ? '1 : RATE_W'(q);
			end
			last_rx = it.rx;
			last_lost = it.lost;
			last_bytes = it.bytes;
			last_time = it.now;
		end
		REQ_FRAME: begin
			n_frames++;
			if (!(it.corrupted || it.dec_only) && !(kf_only && it.delta)) begin
				if (recov_armed && !it.delta) begin
					recov_armed = 1'b0;
					kf_only = 1'b0;
					main_off = 1'b0;
					guard_on = 1'b0;
					restores++;
				end
				v.pass_frame = 1'b1;
				n_passed++;
			end
		end
		REQ_GUARD: begin
			guard_ready = 1'b1;
			if (kf_only)
				guard_on = 1'b1;
		end
		default: ;
		endcase
		v.keyframe_only = kf_only;
		v.recovery_armed = recov_armed;
		v.main_blocked = main_off;
		v.show_guard = guard_on;
		return v;
	endfunction

	// Accept side: predict on each input beat, check each result beat
	always @(posedge clk or negedge arst_n) begin
		rx_item_t it;
		verdict_t got, exp_v;
		if (!arst_n) begin
			item_fire <= 1'b0;
			thr_pm = THR_RESET;
			win_ms = WIN_RESET;
			kf_only = 1'b0;
			recov_armed = 1'b0;
			guard_ready = 1'b0;
			guard_on = 1'b0;
			main_off = 1'b0;
			low_since = '0;
			last_rx = '0;
			last_lost = '0;
			last_bytes = '0;
			last_time = '0;
		end else begin
			item_fire <= item_ch.valid && item_ch.ready;
			if (item_ch.valid && item_ch.ready) begin
				it = {item_ch.req_type, item_ch.rx_pkts, item_ch.lost_pkts,
					item_ch.rx_bytes, item_ch.now_ms, item_ch.frame_corrupted,
					item_ch.frame_decode_only, item_ch.frame_is_delta};
				expected_verdicts.insert(expected_verdicts.size(), predict_verdict(it));
			end
			if (result_ch.valid && result_ch.ready) begin
				got = {result_ch.pass_frame, result_ch.keyframe_only, result_ch.recovery_armed,
					result_ch.main_blocked, result_ch.show_guard, result_ch.loss_permille,
					result_ch.rate_kbps};
				results_seen++;
				if (expected_verdicts.size() == 0) begin
					fail_count++;
					$display("%0t: result beat with nothing expected: pass=%0d kf=%0d rec=%0d",
						$time, got.pass_frame, got.keyframe_only, got.recovery_armed);
				end else begin
					exp_v = expected_verdicts.pop_front();
					if (got !== exp_v) begin
						fail_count++;
						$display("%0t: #%0d expected p=%0d k=%0d r=%0d b=%0d g=%0d loss=%0d rate=%0d",
							$time, results_seen, exp_v.pass_frame, exp_v.keyframe_only,
							exp_v.recovery_armed, exp_v.main_blocked, exp_v.show_guard,
							exp_v.loss_permille, exp_v.rate_kbps);
						$display("%0t: #%0d actual   p=%0d k=%0d r=%0d b=%0d g=%0d loss=%0d rate=%0d",
							$time, results_seen, got.pass_frame, got.keyframe_only,
							got.recovery_armed, got.main_blocked, got.show_guard,
							got.loss_permille, got.rate_kbps);
					end
				end
			end
		end
	end

	// Input driver: bursts of beats separated by random gaps
	int unsigned burst_left = 0, gap_left = 0;

	always @(negedge clk) begin
		rx_item_t nxt;
		logic     offer;
		offer = item_ch.valid && !item_fire;
		if (arst_n && !offer) begin
			if (burst_left == 0 && gap_left == 0) begin
				burst_left = $urandom_range(1, 48);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
			end
			if (burst_left != 0) begin
				if (pending_items.size() != 0) begin
					nxt = pending_items.pop_front();
					burst_left--;
					offer = 1'b1;
					item_ch.req_type <= nxt.kind;
					item_ch.rx_pkts <= nxt.rx;
					item_ch.lost_pkts <= nxt.lost;
					item_ch.rx_bytes <= nxt.bytes;
					item_ch.now_ms <= nxt.now;
					item_ch.frame_corrupted <= nxt.corrupted;
					item_ch.frame_decode_only <= nxt.dec_only;
					item_ch.frame_is_delta <= nxt.delta;
				end
			end else begin
				gap_left--;
			end
		end
		item_ch.valid <= offer;
	end

	// Result receiver: rotating stall pattern plus two long hold-offs
	int unsigned hold_left = 0, next_hold_at = 300, pat_left = 0;
	logic [15:0] stall_pat = '1;

	always @(negedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else if (results_seen >= next_hold_at) begin
			hold_left = 500;
			next_hold_at += 900;
			result_ch.ready <= 1'b0;
		end else begin
			if (pat_left == 0) begin
				pat_left = 64;
				stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom() | $urandom());
			end
			pat_left--;
			stall_pat = {stall_pat[0], stall_pat[15:1]};
			result_ch.ready <= stall_pat[0];
		end
	end

	function automatic rx_item_t random_item(input logic [TYPE_W-1:0] kind);
		rx_item_t it;
		it.kind = kind;
		it.rx = $urandom();
		it.lost = $urandom();
		it.bytes = BYTES_W'({$urandom(), $urandom()});
		it.now = $urandom();
		it.corrupted = 1'($urandom_range(0, 1));
		it.dec_only = 1'($urandom_range(0, 1));
		it.delta = 1'($urandom_range(0, 1));
		return it;
	endfunction

	task automatic queue_sample(input logic [CNT_W-1:0] rx, input logic [CNT_W-1:0] lost,
			input logic [BYTES_W-1:0] bytes, input logic [TIME_W-1:0] now);
		rx_item_t it;
		it = random_item(REQ_SAMPLE);
		it.rx = rx;
		it.lost = lost;
		it.bytes = bytes;
		it.now = now;
		pending_items.insert(pending_items.size(), it);
	endtask

	task automatic queue_frame(input logic corrupted, input logic dec_only, input logic delta);
		rx_item_t it;
		it = random_item(REQ_FRAME);
		it.corrupted = corrupted;
		it.dec_only = dec_only;
		it.delta = delta;
		pending_items.insert(pending_items.size(), it);
	endtask

	task automatic queue_stream_sample(input bit lossy);
		int unsigned rx_inc, lost_inc, step;
		rx_inc = $urandom_range(0, 400);
		if (lossy) begin
			lost_inc = $urandom_range(rx_inc / 4 + 1, rx_inc + 50);
		end else if (thr_pm <= 1000 && $urandom_range(0, 19) == 0) begin
			// interval loss lands exactly on the threshold
			rx_inc = 1000 - 32'(thr_pm);
			lost_inc = 32'(thr_pm);
		end else begin
			lost_inc = $urandom_range(0, rx_inc / 40);
		end
		step = $urandom_range(1, win_ms / 2 + 40);
		s_rx += rx_inc;
		s_lost += lost_inc;
		s_bytes += BYTES_W'($urandom_range(0, 3000000));
		s_now += step;
		queue_sample(s_rx, s_lost, s_bytes, s_now);
	endtask

	task automatic queue_traffic(input int unsigned n);
		int unsigned made, r, nfr;
		made = 0;
		while (made < n) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				if (bad_left == 0 && $urandom_range(0, 9) == 0)
					bad_left = $urandom_range(1, 3);
				queue_stream_sample(bad_left != 0);
				if (bad_left != 0)
					bad_left--;
				nfr = $urandom_range(0, 3);
				repeat (nfr)
					queue_frame($urandom_range(0, 15) == 0, $urandom_range(0, 15) == 0,
						$urandom_range(0, 3) != 0);
				made += 1 + nfr;
			end else if (r < 80) begin
				pending_items.insert(pending_items.size(), random_item(REQ_FRAME));
				made++;
			end else if (r < 85) begin
				pending_items.insert(pending_items.size(), random_item(REQ_GUARD));
				made++;
			end else if (r < 95) begin
				case ($urandom_range(0, 3))
				0: pending_items.insert(pending_items.size(), random_item(REQ_SAMPLE));
				1: queue_sample(s_rx, s_lost, s_bytes,
					($urandom_range(0, 1) == 0) ? '0 : TIME_W'($urandom_range(0, s_now)));
				2: queue_sample(s_rx, s_lost, s_bytes - BYTES_W'($urandom_range(1, 5000)),
					s_now + 1);
				default: begin
					// byte jump large enough to saturate the rate
					s_bytes += BYTES_W'({$urandom_range(256, 65535), 32'h0});
					s_now += 1;
					queue_sample(s_rx, s_lost, s_bytes, s_now);
				end
				endcase
				made++;
			end else begin
				pending_items.insert(pending_items.size(), random_item(REQ_UNUSED));
				made++;
			end
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		if (idx == REG_LOSS_THR)
			thr_pm = data[THR_W-1:0];
		else if (idx == REG_UPSHIFT_WIN)
			win_ms = data;
	endtask

	task automatic program_regs(input logic [CFG_DATA_W-1:0] thr_word,
			input logic [CFG_DATA_W-1:0] win_word, input bit stray);
		write_reg(REG_LOSS_THR, thr_word);
		write_reg(REG_UPSHIFT_WIN, win_word);
		if (stray)
			write_reg(CFG_IDX_W'($urandom_range(int'(REG_UPSHIFT_WIN) + 1, 255)),
				CFG_DATA_W'($urandom()));
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic wait_idle;
		do @(posedge clk);
		while (pending_items.size() != 0 || item_ch.valid === 1'b1 ||
			expected_verdicts.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.req_type = REQ_SAMPLE;
		item_ch.rx_pkts = '0;
		item_ch.lost_pkts = '0;
		item_ch.rx_bytes = '0;
		item_ch.now_ms = '0;
		item_ch.frame_corrupted = 1'b0;
		item_ch.frame_decode_only = 1'b0;
		item_ch.frame_is_delta = 1'b0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_LOSS_THR;
		cfg_ch.data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed walk through entry, guard display and recovery, default registers
		queue_sample(0, 0, 0, 0);
		queue_sample(100, 10, 48'd5000, 1000);
		queue_sample(190, 20, 48'd9000, 2000);
		queue_sample(200, 40, 48'd12000, 2500);
		queue_frame(1'b0, 1'b0, 1'b1);
		queue_frame(1'b1, 1'b0, 1'b0);
		queue_frame(1'b0, 1'b1, 1'b0);
		pending_items.insert(pending_items.size(), random_item(REQ_GUARD));
		queue_sample(1200, 40, 48'd20000, 3000);
		queue_sample(1290, 50, 48'd30000, 3200);
		queue_sample(2290, 50, 48'd40000, 4000);
		queue_sample(3290, 50, 48'd50000, 3500);
		queue_sample(4290, 50, 48'd60000, 6000);
		queue_frame(1'b0, 1'b0, 1'b1);
		queue_frame(1'b0, 1'b0, 1'b0);
		queue_sample(4240, 150, 48'd1000, 6100);
		queue_sample(4240, 150, 48'd1000 + (48'd1 << 40), 6101);
		pending_items.insert(pending_items.size(), random_item(REQ_UNUSED));
		queue_frame(1'b0, 1'b0, 1'b0);
		queue_sample('1, '1, '1, '1);
		queue_sample(0, 0, 0, 0);
		queue_sample(10, 0, 48'd100, 500);
		wait_idle();

		program_regs(16'd1000, 16'd0, 1'b0);
		queue_traffic(250);
		wait_idle();

		program_regs(16'd0, 16'hFFFF, 1'b1);
		queue_traffic(250);
		wait_idle();

		// junk above the threshold field is dropped by the register
		program_regs(16'hFC00 | 16'(THR_RESET), 16'(WIN_RESET), 1'b1);
		queue_traffic(500);
		wait_idle();

		program_regs(16'($urandom_range(1, 300)), 16'($urandom_range(0, 5000)), 1'b0);
		queue_traffic(400);
		wait_idle();

		program_regs(16'($urandom_range(0, 1000)), 16'($urandom_range(0, 65535)), 1'b1);
		queue_traffic(400);
		wait_idle();
		repeat (80) @(posedge clk);

		$display("Checked %0d results: %0d samples, %0d frames (%0d forwarded).",
			results_seen, n_samples, n_frames, n_passed);
		$display("Guard mode entered %0d times, main video restored %0d times, 6 settings.",
			mode_entries, restores);
		if (fail_count == 0 && expected_verdicts.size() == 0)
			$display("loss_driven_keyframe_guard_mode verification clean");
		else
			$display("loss_driven_keyframe_guard_mode verification failed");
		$finish;
	end

	initial begin
		#15_000_000;
		$display("%0t: timeout, %0d results outstanding", $time, expected_verdicts.size());
		$display("loss_driven_keyframe_guard_mode verification failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/lkg_pkg.sv
rtl/core/lkg_if.sv
rtl/core/lkg_div.sv
rtl/core/lkg_dp.sv
rtl/core/lkg_ctrl.sv
rtl/core/loss_driven_keyframe_guard_mode.sv
test/tb_top.sv
